@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// clocked property checks that can be compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define MI_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// condition must never be seen at a clock edge outside reset
`define MI_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define MI_ASSERT(lbl, clk, rst_n, prop)
`define MI_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ design/mi_pkg.sv @@
// ---------------------------------------------------------------------------
// mi_pkg
// shared types and constants of the modular inverse unit
// ---------------------------------------------------------------------------
`default_nettype none

package mi_pkg;

	localparam int WORD_BITS_DEF = 16;
	localparam int INV_BITS      = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK_M,
		ST_REDUCE,
		ST_CHECK_V,
		ST_DIV,
		ST_EVAL,
		ST_FINISH
	} state_t;

	// what the output register takes
	typedef enum logic [1:0] {
		RES_NONE,   // no inverse: 0, status 1
		RES_UNIT,   // modulus one: 0, status 0
		RES_ONE,    // value congruent to one: 1, status 0
		RES_COEF    // coefficient of the last row, status 0
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     step;
		logic     start;
		logic     next;
		logic     out_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic m_zero;
		logic m_one;
		logic rem_zero;
		logic rem_one;
	} status_t;

endpackage

`default_nettype wire

@@ design/mi_ctrl.sv @@
// ---------------------------------------------------------------------------
// mi_ctrl
// sequencer for the reduction pass and the euclid rows, output valid flag
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mi_ctrl #(
	parameter int WORD_BITS = mi_pkg::WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  mi_pkg::status_t  status,
	output mi_pkg::cmd_t     cmd
);

	localparam int CNT_BITS = $clog2(WORD_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

	mi_pkg::state_t   state_q, state_d;
	mi_pkg::res_sel_t res_q, res_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mi_pkg::ST_IDLE;
			res_q       <= mi_pkg::RES_NONE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_q       <= res_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		res_d        = res_q;
		cnt_d        = cnt_q;
		cmd.load     = 1'b0;
		cmd.step     = 1'b0;
		cmd.start    = 1'b0;
		cmd.next     = 1'b0;
		cmd.out_load = 1'b0;
		cmd.res_sel  = res_q;
		case (state_q)
			mi_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = mi_pkg::ST_CHECK_M;
				end
			end
			mi_pkg::ST_CHECK_M: begin
				if (status.m_zero) begin
					res_d   = mi_pkg::RES_NONE;
					state_d = mi_pkg::ST_FINISH;
				end else if (status.m_one) begin
					res_d   = mi_pkg::RES_UNIT;
					state_d = mi_pkg::ST_FINISH;
				end else begin
					cnt_d   = '0;
					state_d = mi_pkg::ST_REDUCE;
				end
			end
			mi_pkg::ST_REDUCE: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = mi_pkg::ST_CHECK_V;
				end
			end
			mi_pkg::ST_CHECK_V: begin
				if (status.rem_zero) begin
					res_d   = mi_pkg::RES_NONE;
					state_d = mi_pkg::ST_FINISH;
				end else if (status.rem_one) begin
					res_d   = mi_pkg::RES_ONE;
					state_d = mi_pkg::ST_FINISH;
				end else begin
					cmd.start = 1'b1;
					cnt_d     = '0;
					state_d   = mi_pkg::ST_DIV;
				end
			end
			mi_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = mi_pkg::ST_EVAL;
				end
			end
			mi_pkg::ST_EVAL: begin
				if (status.rem_one) begin
					res_d   = mi_pkg::RES_COEF;
					state_d = mi_pkg::ST_FINISH;
				end else if (status.rem_zero) begin
					res_d   = mi_pkg::RES_NONE;
					state_d = mi_pkg::ST_FINISH;
				end else begin
					cmd.next = 1'b1;
					cnt_d    = '0;
					state_d  = mi_pkg::ST_DIV;
				end
			end
			mi_pkg::ST_FINISH: begin
				// wait until the output register is free or being drained
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = mi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mi_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end else if (m_tready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign s_tready = (state_q == mi_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;

	`MI_ASSERT(a_load_then_check, clk, arst_n, cmd.load |=> state_q == mi_pkg::ST_CHECK_M)
	`MI_ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.out_load && out_valid_q && !m_tready)
	`MI_ASSERT(a_finish_leaves_valid, clk, arst_n, cmd.out_load |=> out_valid_q)

endmodule

`default_nettype wire

@@ design/mi_dp.sv @@
// ---------------------------------------------------------------------------
// mi_dp
// bit-serial divider with a fused modular multiply-accumulate, euclid rows
// and the output register
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mi_dp #(
	parameter int WORD_BITS = mi_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [WORD_BITS-1:0]        modulus,
	input  logic [WORD_BITS-1:0]        value,
	input  mi_pkg::cmd_t                cmd,
	output mi_pkg::status_t             status,
	output logic [mi_pkg::INV_BITS-1:0] inverse,
	output logic                        inv_status
);

	logic [WORD_BITS-1:0] m_q;
	logic [WORD_BITS-1:0] a_q;     // dividend, shifted out msb first
	logic [WORD_BITS-1:0] b_q;     // divisor
	logic [WORD_BITS-1:0] rem_q;
	logic [WORD_BITS-1:0] acc_q;   // quotient times botb, mod m
	logic [WORD_BITS-1:0] bota_q;
	logic [WORD_BITS-1:0] botb_q;
	logic [mi_pkg::INV_BITS-1:0] inv_q;
	logic stat_q;

	logic [WORD_BITS:0]   shifted;
	logic [WORD_BITS:0]   diff;
	logic                 qbit;
	logic [WORD_BITS-1:0] rem_n;
	logic [WORD_BITS-1:0] acc_dbl;
	logic [WORD_BITS-1:0] acc_n;
	logic [WORD_BITS-1:0] coef;

	function automatic logic [WORD_BITS-1:0] add_mod(
		input logic [WORD_BITS-1:0] x,
		input logic [WORD_BITS-1:0] y,
		input logic [WORD_BITS-1:0] m
	);
		logic [WORD_BITS:0] s;
		logic [WORD_BITS:0] t;
		s = {1'b0, x} + {1'b0, y};
		t = s - {1'b0, m};
		if (s >= {1'b0, m}) begin
			return t[WORD_BITS-1:0];
		end
		return s[WORD_BITS-1:0];
	endfunction

	assign shifted = {rem_q, a_q[WORD_BITS-1]};
	assign diff    = shifted - {1'b0, b_q};
	assign qbit    = (shifted >= {1'b0, b_q});
	assign rem_n   = qbit ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
	assign acc_dbl = add_mod(acc_q, acc_q, m_q);
	assign acc_n   = qbit ? add_mod(acc_dbl, botb_q, m_q) : acc_dbl;
	// bota - q*botb mod m, both terms already below m
	assign coef    = (bota_q >= acc_q) ? (bota_q - acc_q) : (bota_q + (m_q - acc_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q    <= modulus;
			a_q    <= value;
			b_q    <= modulus;
			rem_q  <= '0;
			acc_q  <= '0;
			botb_q <= '0;
		end else if (cmd.step) begin
			a_q   <= {a_q[WORD_BITS-2:0], 1'b0};
			rem_q <= rem_n;
			acc_q <= acc_n;
		end else if (cmd.start) begin
			a_q    <= m_q;
			b_q    <= rem_q;
			rem_q  <= '0;
			acc_q  <= '0;
			bota_q <= '0;
			botb_q <= WORD_BITS'(1);
		end else if (cmd.next) begin
			a_q    <= b_q;
			b_q    <= rem_q;
			rem_q  <= '0;
			acc_q  <= '0;
			bota_q <= botb_q;
			botb_q <= coef;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.res_sel)
				mi_pkg::RES_NONE: begin
					inv_q  <= '0;
					stat_q <= 1'b1;
				end
				mi_pkg::RES_UNIT: begin
					inv_q  <= '0;
					stat_q <= 1'b0;
				end
				mi_pkg::RES_ONE: begin
					inv_q  <= mi_pkg::INV_BITS'(1);
					stat_q <= 1'b0;
				end
				mi_pkg::RES_COEF: begin
					inv_q  <= mi_pkg::INV_BITS'(coef);
					stat_q <= 1'b0;
				end
				default: begin
					inv_q  <= '0;
					stat_q <= 1'b1;
				end
			endcase
		end
	end

	assign status.m_zero   = (m_q == '0);
	assign status.m_one    = (m_q == WORD_BITS'(1));
	assign status.rem_zero = (rem_q == '0);
	assign status.rem_one  = (rem_q == WORD_BITS'(1));
	assign inverse    = inv_q;
	assign inv_status = stat_q;

	`MI_ASSERT(a_rem_below_div, clk, arst_n, (cmd.step && b_q != '0) |=> rem_q < b_q)
	`MI_ASSERT(a_coef_reduced, clk, arst_n, cmd.next |=> botb_q < m_q)

endmodule

`default_nettype wire

@@ design/modular_inverse_unit.sv @@
// ---------------------------------------------------------------------------
// modular_inverse_unit
// modular inverse by the extended euclid table, one item at a time
// ---------------------------------------------------------------------------
// Takes a modulus and a value and returns the inverse of the value modulo the
// modulus, with status 1 and inverse 0 when the gcd is not 1. One item is
// worked on at a time: after the input beat come a check of the modulus, a
// reduction of the value modulo the modulus, a check of the remainder, then a
// division and an evaluation for every euclid row, and finally the load of
// the output register; 16-bit operands need at most about 23 rows. The row
// time is set by the one-bit-per-cycle divider, which forms the quotient times
// coefficient product mod the modulus on the fly. A modulus of zero or one
// finishes after the first check, and a value that reduces to zero or one
// after the check of the remainder. The next input beat is taken as soon as
// the result sits in the output register.
`default_nettype none

module modular_inverse_unit #(
	parameter int WORD_BITS = mi_pkg::WORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((2*WORD_BITS+7)/8)*8-1:0]     s_tdata,   // modulus, value
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mi_pkg::INV_BITS-1:0]          m_tdata,   // inverse
	output logic                                 m_tuser    // status
);

	mi_pkg::cmd_t    cmd;
	mi_pkg::status_t status;

	mi_ctrl #(
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mi_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.modulus    (s_tdata[WORD_BITS-1:0]),
		.value      (s_tdata[2*WORD_BITS-1:WORD_BITS]),
		.cmd        (cmd),
		.status     (status),
		.inverse    (m_tdata),
		.inv_status (m_tuser)
	);

endmodule

`default_nettype wire

@@ sim/modular_inverse_unit_tb.sv @@
// ---------------------------------------------------------------------------
// modular_inverse_unit_tb
// self-checking bench for the extended euclid modular inverse unit
// ---------------------------------------------------------------------------
// Sends (modulus, value) beats on the slave stream and predicts each
// (inverse, status) result with a table walk of its own. Results are checked
// in order as they leave the master stream. Directed corners come first, then
// a pause where the sender waits for every result to drain, then random
// operands with random stalls on both sides and one stretch with none.
// ---------------------------------------------------------------------------

module modular_inverse_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD      = 16;
	localparam int IN_BITS   = ((2*WORD+7)/8)*8;
	localparam int IDLE_PCT  = 9;
	localparam int N_RANDOM  = 1500;
	localparam int DONE_WAIT = 500;
	localparam int STUCK_MAX = 20000;

	typedef struct packed {
		logic [mi_pkg::INV_BITS-1:0] inverse;
		logic                        status;
	} inv_result_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [IN_BITS-1:0]          s_tdata = '0;   // modulus, value
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [mi_pkg::INV_BITS-1:0] m_tdata;        // inverse
	logic                        m_tuser;        // status

	inv_result_t pending_inverses[$];
	int          err_count = 0;
	int          stuck_cycles = 0;
	bit          no_idle = 1'b0;

	modular_inverse_unit #(
		.WORD_BITS(WORD)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// two-row euclid table, coefficients kept reduced mod the modulus
	function automatic inv_result_t mod_inverse(input logic [WORD-1:0] modulus,
	                                            input logic [WORD-1:0] value);
		longint unsigned m, rem_a, rem_b, coef_a, coef_b, quot, rem, coef, prod;
		inv_result_t res;
		bit done;
		m = modulus;
		rem_b = value;
		res.inverse = '0;
		res.status = 1'b1;
		done = 1'b0;
		if (m == 1) begin
			res.status = 1'b0;
		end else if (m != 0) begin
			rem_b = rem_b % m;
			if (rem_b == 1) begin
				res.inverse = 1;
				res.status = 1'b0;
			end else if (rem_b != 0) begin
				rem_a = m;
				coef_a = 0;
				coef_b = 1;
				while (!done) begin
					quot = rem_a / rem_b;
					rem = rem_a - quot * rem_b;
					prod = ((quot % m) * coef_b) % m;
					coef = (coef_a + m - prod) % m;
					if (rem == 1) begin
						res.inverse = coef[WORD-1:0];
						res.status = 1'b0;
						done = 1'b1;
					end else if (rem == 0) begin
						done = 1'b1;
					end else begin
						rem_a = rem_b;
						rem_b = rem;
						coef_a = coef_b;
						coef_b = coef;
					end
				end
			end
		end
		return res;
	endfunction

	task automatic send_operands(input logic [WORD-1:0] modulus, input logic [WORD-1:0] value);
		int gap;
		gap = (!no_idle && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 6) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {value, modulus};
		do @(posedge clk); while (!s_tready);
		pending_inverses.push_back(mod_inverse(modulus, value));
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_inverses.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_special_cases();
		send_operands(16'd0, 16'd5);        // modulus zero
		send_operands(16'd0, 16'd0);
		send_operands(16'd1, 16'd1234);     // modulus one
		send_operands(16'd1, 16'd0);
		send_operands(16'd7, 16'd1);        // value one
		send_operands(16'd7, 16'd8);        // reduces to one
		send_operands(16'd7, 16'd0);        // value zero
		send_operands(16'd12, 16'd36);      // multiple of modulus
		send_operands(16'd12, 16'd12);
		send_operands(16'd12, 16'd8);       // common factor
		send_operands(16'd65535, 16'd65535);
	endtask

	task automatic test_extremes();
		send_operands(16'd65535, 16'd65534);
		send_operands(16'd65535, 16'd2);
		send_operands(16'd46368, 16'd28657); // fibonacci pair, longest table
		send_operands(16'd2, 16'd1);
		send_operands(16'd2, 16'd3);
		send_operands(16'd65521, 16'd65520);
		send_operands(16'hFFFF, 16'h8000);
		send_operands(16'h8001, 16'hFFFF);
		send_operands(16'd3, 16'd2);
		send_operands(16'd40000, 16'd39999); // single row with a negative coefficient
	endtask

	task automatic test_random_operands(input int count);
		logic [WORD-1:0] modulus, value;
		int kind;
		for (int i = 0; i < count; i++) begin
			no_idle = (i >= count / 3) && (i < count / 3 + 300);
			kind = $urandom_range(0, 99);
			modulus = $urandom_range(0, 65535);
			value = $urandom_range(0, 65535);
			if (kind >= 70 && kind < 85) begin
				modulus = $urandom_range(2, 255);
			end else if (kind >= 85 && kind < 92) begin
				modulus = $urandom_range(2, 255);
				value = modulus * $urandom_range(0, 255);
			end else if (kind >= 92 && kind < 96) begin
				modulus = $urandom_range(2, 1000);
				value = modulus * $urandom_range(0, 60) + 1;
			end else if (kind >= 96) begin
				modulus = $urandom_range(0, 2);
			end
			send_operands(modulus, value);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 20; i++)
			send_operands($urandom_range(2, 65535), $urandom_range(1, 65535));
		drain_results();
		for (int i = 0; i < 20; i++)
			send_operands($urandom_range(2, 65535), $urandom_range(1, 65535));
	endtask

	always @(negedge clk)
		m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk) begin
		inv_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_inverses.size() == 0) begin
				$error("result beat with nothing pending: inverse %0d status %0d",
				       m_tdata, m_tuser);
				err_count++;
			end else begin
				want = pending_inverses.pop_front();
				if (m_tdata !== want.inverse) begin
					$error("inverse: expected %0d, got %0d", want.inverse, m_tdata);
					err_count++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					err_count++;
				end
			end
		end
	end

	// ends the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_MAX) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_special_cases();
		test_extremes();
		test_drain_pause();
		test_random_operands(N_RANDOM);
		drain_results();
		repeat (DONE_WAIT) @(posedge clk);
		if (err_count == 0 && pending_inverses.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
